// ===== design/qas_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrature angle and speed package
// Shared widths, codes, item types, controller states and the output
// saturation helper of the two-channel encoder angle and speed block.
// ----------------------------------------------------------------------------
package qas_pkg;

	// Field and datapath widths.
	localparam int unsigned WRAP_W   = 32;
	localparam int unsigned CNT_W    = 16;
	localparam int unsigned POS_W    = WRAP_W + CNT_W;
	localparam int unsigned DIFF_W   = POS_W + 1;
	localparam int unsigned RES_W    = 15;
	localparam int unsigned TICK_W   = 32;
	localparam int unsigned OUT_W    = 32;
	localparam int unsigned CFG_IDX_W = 2;

	// Serial multiplier and divider widths.
	localparam int unsigned MCAND_W  = 48;
	localparam int unsigned MPLIER_W = 15;
	localparam int unsigned PROD_W   = MCAND_W + MPLIER_W;
	localparam int unsigned NUM_W    = 70;
	localparam int unsigned DEN_W    = RES_W + TICK_W;
	localparam int unsigned QUOT_W   = 32;
	localparam int unsigned STEP_W   = 5;

	// Scale factors: degrees per quarter line, and rpm per line per ms before Q8.
	localparam logic [MPLIER_W-1:0] ANGLE_SCALE = 15'd90;
	localparam logic [MPLIER_W-1:0] SPEED_SCALE = 15'd15000;
	localparam int unsigned         Q_SHIFT     = 8;

	// Request codes.
	localparam logic [1:0] REQ_WRAP   = 2'd0;
	localparam logic [1:0] REQ_TICK   = 2'd1;
	localparam logic [1:0] REQ_SAMPLE = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_RESOLUTION_A = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RESOLUTION_B = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERT_A     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERT_B     = 2'd3;

	localparam logic [OUT_W-1:0] S32_MAX = 32'h7FFF_FFFF;
	localparam logic [OUT_W-1:0] S32_MIN = 32'h8000_0000;

	typedef struct packed {
		logic [1:0]       req_type;
		logic             wrap_channel;
		logic             wrap_upward;
		logic [CNT_W-1:0] count_a;
		logic [CNT_W-1:0] count_b;
		logic             clear_a;
		logic             clear_b;
	} qas_req_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] angle_a;
		logic signed [OUT_W-1:0] angle_b;
		logic signed [OUT_W-1:0] speed_a;
		logic signed [OUT_W-1:0] speed_b;
		logic                    speed_fresh;
	} qas_rsp_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} qas_div_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ANG_MUL,
		ST_ANG_DIV,
		ST_DEN_MUL,
		ST_NUM_MUL,
		ST_SPD_DIV,
		ST_DONE
	} qas_state_t;

	// Applies a sign to a quotient magnitude and clamps it to 32 signed bits.
	// ovf means the magnitude reached 2^32 or more.
	function automatic logic [OUT_W-1:0] sat_word(input logic neg, input logic ovf,
			input logic [QUOT_W-1:0] q);
		logic big;
		big = ovf | q[QUOT_W-1];
		if (neg) begin
			sat_word = big ? S32_MIN : (~q + 32'd1);
		end else begin
			sat_word = big ? S32_MAX : q;
		end
	endfunction

endpackage

// ===== design/qas_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrature angle and speed stream interface
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface qas_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== design/qas_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrature angle and speed serial multiplier
// Shift-and-add multiplier that retires one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module qas_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [qas_pkg::MCAND_W-1:0]   mcand,
	input  logic [qas_pkg::MPLIER_W-1:0]  mplier,
	output logic                          done,
	output logic [qas_pkg::PROD_W-1:0]    product
);

	logic                          busy_q;
	logic                          done_q;
	logic [qas_pkg::PROD_W-1:0]    acc_q;
	logic [qas_pkg::PROD_W-1:0]    mcand_q;
	logic [qas_pkg::MPLIER_W-1:0]  mplier_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (mplier_q == '0)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// The multiplier shifts right and the multiplicand left, one bit a cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			mcand_q  <= qas_pkg::PROD_W'(mcand);
			mplier_q <= mplier;
		end else if (busy_q && (mplier_q != '0)) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

// ===== design/qas_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrature angle and speed serial divider
// Restoring divider producing a 32-bit quotient one bit per cycle, with an
// up-front check for quotients of 2^32 or more.
// ----------------------------------------------------------------------------
module qas_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [qas_pkg::NUM_W-1:0]    num,
	input  logic [qas_pkg::DEN_W-1:0]    den,
	output qas_pkg::qas_div_stat_t       stat,
	output logic [qas_pkg::QUOT_W-1:0]   quot
);

	localparam int unsigned HI_W = qas_pkg::NUM_W - qas_pkg::QUOT_W;

	logic                          busy_q;
	logic                          done_q;
	logic                          ovf_q;
	logic [qas_pkg::STEP_W-1:0]    step_q;
	logic [qas_pkg::DEN_W-1:0]     rem_q;
	logic [qas_pkg::DEN_W-1:0]     den_q;
	logic [qas_pkg::QUOT_W-1:0]    low_q;
	logic                          start_ovf;
	logic [qas_pkg::DEN_W:0]       trial;
	logic [qas_pkg::DEN_W+1:0]     sub;
	logic                          take;

	// The quotient overflows 32 bits exactly when the upper numerator part
	// already reaches the divisor.
	assign start_ovf = qas_pkg::DEN_W'(num[qas_pkg::NUM_W-1:qas_pkg::QUOT_W]) >= den;

	assign trial = {rem_q, low_q[qas_pkg::QUOT_W-1]};
	assign sub   = {1'b0, trial} - {2'b00, den_q};
	assign take  = !sub[qas_pkg::DEN_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ovf_q  <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= !start_ovf;
				done_q <= start_ovf;
				ovf_q  <= start_ovf;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + qas_pkg::STEP_W'(1);
				if (step_q == '1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// low_q holds the numerator bits still to come and collects quotient bits.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= qas_pkg::DEN_W'(num[qas_pkg::NUM_W-1:qas_pkg::QUOT_W]);
			low_q <= num[qas_pkg::QUOT_W-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= take ? sub[qas_pkg::DEN_W-1:0] : trial[qas_pkg::DEN_W-1:0];
			low_q <= {low_q[qas_pkg::QUOT_W-2:0], take};
		end
	end

	assign stat.done = done_q;
	assign stat.ovf  = ovf_q;
	assign quot      = low_q;

	// HI_W documents the width of the upper numerator slice.
	if (HI_W > qas_pkg::DEN_W) begin : g_width_guard
		$error("numerator upper part wider than divisor");
	end

endmodule

// ===== design/quadrature_angle_and_speed_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrature angle and speed core
// Two-channel encoder position tracker that turns wrap events, millisecond
// ticks and sample requests into angles in degrees and speeds in Q23.8 rpm.
// ----------------------------------------------------------------------------
//
//  Channel   Kind                 Payload      Transfer
//  --------  -------------------  -----------  -------------------------------
//  req_ch    stream sink          qas_req_t    valid && ready at clk rise
//  rsp_ch    stream source        qas_rsp_t    valid && ready at clk rise
//  cfg       write port           cfg_data     cfg_we high at clk rise
//
//  A wrap or tick request is absorbed in the cycle of its transfer. A sample
//  request runs one shared shift-and-add multiplier (one multiplier bit per
//  cycle) and one shared restoring divider (one quotient bit per cycle) over
//  both channels; speeds are recomputed only when a tick has elapsed, and the
//  32-step divider sets most of the time a sample takes. Requests are refused
//  while a sample is in work.
//  Reset clears the position, tick and speed state and loads resolutions of
//  one. A result waits in the output register while the next request is taken;
//  only a further finished sample waits for that register to drain.
//
module quadrature_angle_and_speed_core (
	input  logic                              clk,
	input  logic                              arst_n,
	qas_stream_if.sink                        req_ch,
	qas_stream_if.source                      rsp_ch,
	input  logic                              cfg_we,
	input  logic [qas_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [qas_pkg::RES_W-1:0]         cfg_data
);

	qas_pkg::qas_req_t             req_item;
	qas_pkg::qas_rsp_t             rsp_data_q;
	logic                          rsp_valid_q;

	qas_pkg::qas_state_t           state_q;
	qas_pkg::qas_state_t           state_d;
	logic                          ch_q;
	logic                          issued_q;
	logic                          fresh_q;

	// Configuration.
	logic [qas_pkg::RES_W-1:0]     res_q [2];
	logic                          inv_q [2];

	// Architectural state.
	logic [qas_pkg::WRAP_W-1:0]    wrap_q [2];
	logic [qas_pkg::POS_W-1:0]     prev_q [2];
	logic [qas_pkg::TICK_W-1:0]    ticks_q;
	logic [qas_pkg::OUT_W-1:0]     held_q [2];

	// Per-sample working registers.
	logic [qas_pkg::POS_W-1:0]     full_q [2];
	logic [qas_pkg::DIFF_W-1:0]    diff_q [2];
	logic [qas_pkg::OUT_W-1:0]     ang_q [2];
	logic [qas_pkg::DEN_W-1:0]     den_q;

	logic                          req_fire;
	logic                          rsp_fire;
	logic                          rsp_load;
	logic [qas_pkg::POS_W-1:0]     pos_next [2];

	logic [qas_pkg::RES_W-1:0]     res_eff;
	logic [qas_pkg::POS_W-1:0]     full_sel;
	logic [qas_pkg::DIFF_W-1:0]    diff_sel;
	logic [qas_pkg::POS_W-1:0]     full_neg;
	logic [qas_pkg::MCAND_W-1:0]   full_mag;
	logic [qas_pkg::DIFF_W-1:0]    diff_neg;
	logic [qas_pkg::MCAND_W-1:0]   diff_mag;

	logic                          mul_start;
	logic [qas_pkg::MCAND_W-1:0]   mul_mcand;
	logic [qas_pkg::MPLIER_W-1:0]  mul_mplier;
	logic                          mul_done;
	logic [qas_pkg::PROD_W-1:0]    mul_prod;

	logic                          div_start;
	logic [qas_pkg::NUM_W-1:0]     div_num;
	logic [qas_pkg::DEN_W-1:0]     div_den;
	qas_pkg::qas_div_stat_t        div_stat;
	logic [qas_pkg::QUOT_W-1:0]    div_quot;

	assign req_item       = req_ch.payload;
	assign req_ch.ready   = (state_q == qas_pkg::ST_IDLE);
	assign req_fire       = req_ch.valid && req_ch.ready;
	assign rsp_ch.valid   = rsp_valid_q;
	assign rsp_ch.payload = rsp_data_q;
	assign rsp_fire       = rsp_ch.valid && rsp_ch.ready;

	// A clear flag takes both the wrap count and the hardware count as zero, so
	// the full position is zero. Otherwise it is the wrap count over the count.
	assign pos_next[0] = req_item.clear_a ? '0 : {wrap_q[0], req_item.count_a};
	assign pos_next[1] = req_item.clear_b ? '0 : {wrap_q[1], req_item.count_b};

	// Operands of the channel in work. A resolution of zero acts as one.
	assign res_eff  = (res_q[ch_q] == '0) ? qas_pkg::RES_W'(1) : res_q[ch_q];
	assign full_sel = full_q[ch_q];
	assign diff_sel = diff_q[ch_q];
	assign full_neg = ~full_sel + qas_pkg::POS_W'(1);
	assign full_mag = full_sel[qas_pkg::POS_W-1] ? full_neg : full_sel;
	assign diff_neg = ~diff_sel + qas_pkg::DIFF_W'(1);
	assign diff_mag = diff_sel[qas_pkg::DIFF_W-1] ? diff_neg[qas_pkg::MCAND_W-1:0]
		: diff_sel[qas_pkg::MCAND_W-1:0];

	qas_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (mul_mcand),
		.mplier  (mul_mplier),
		.done    (mul_done),
		.product (mul_prod)
	);

	qas_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.stat   (div_stat),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qas_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer. Each arithmetic state launches its unit once and moves on
	// when the unit reports done. Channel A runs first, then channel B.
	always_comb begin
		state_d    = state_q;
		mul_start  = 1'b0;
		div_start  = 1'b0;
		rsp_load   = 1'b0;
		mul_mcand  = full_mag;
		mul_mplier = qas_pkg::ANGLE_SCALE;
		div_num    = qas_pkg::NUM_W'(mul_prod);
		div_den    = qas_pkg::DEN_W'(res_eff);
		case (state_q)
			qas_pkg::ST_IDLE: begin
				if (req_fire && (req_item.req_type == qas_pkg::REQ_SAMPLE)) begin
					state_d = qas_pkg::ST_ANG_MUL;
				end
			end
			qas_pkg::ST_ANG_MUL: begin
				mul_start = !issued_q;
				if (mul_done) begin
					state_d = qas_pkg::ST_ANG_DIV;
				end
			end
			qas_pkg::ST_ANG_DIV: begin
				div_start = !issued_q;
				if (div_stat.done) begin
					if (fresh_q) begin
						state_d = qas_pkg::ST_DEN_MUL;
					end else if (ch_q) begin
						state_d = qas_pkg::ST_DONE;
					end else begin
						state_d = qas_pkg::ST_ANG_MUL;
					end
				end
			end
			qas_pkg::ST_DEN_MUL: begin
				mul_mcand  = qas_pkg::MCAND_W'(ticks_q);
				mul_mplier = res_eff;
				mul_start  = !issued_q;
				if (mul_done) begin
					state_d = qas_pkg::ST_NUM_MUL;
				end
			end
			qas_pkg::ST_NUM_MUL: begin
				mul_mcand  = diff_mag;
				mul_mplier = qas_pkg::SPEED_SCALE;
				mul_start  = !issued_q;
				if (mul_done) begin
					state_d = qas_pkg::ST_SPD_DIV;
				end
			end
			qas_pkg::ST_SPD_DIV: begin
				// The product stays below 2^62, so the Q8 shift fits the numerator.
				div_num   = {mul_prod[qas_pkg::NUM_W-qas_pkg::Q_SHIFT-1:0],
					{qas_pkg::Q_SHIFT{1'b0}}};
				div_den   = den_q;
				div_start = !issued_q;
				if (div_stat.done) begin
					state_d = ch_q ? qas_pkg::ST_DONE : qas_pkg::ST_ANG_MUL;
				end
			end
			qas_pkg::ST_DONE: begin
				if (!rsp_valid_q || rsp_ch.ready) begin
					rsp_load = 1'b1;
					state_d  = qas_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = qas_pkg::ST_IDLE;
			end
		endcase
	end

	// Control, configuration and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q        <= 1'b0;
			issued_q    <= 1'b0;
			fresh_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
			res_q[0]    <= qas_pkg::RES_W'(1);
			res_q[1]    <= qas_pkg::RES_W'(1);
			inv_q[0]    <= 1'b0;
			inv_q[1]    <= 1'b0;
			wrap_q[0]   <= '0;
			wrap_q[1]   <= '0;
			prev_q[0]   <= '0;
			prev_q[1]   <= '0;
			ticks_q     <= '0;
			held_q[0]   <= '0;
			held_q[1]   <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					qas_pkg::CFG_RESOLUTION_A: res_q[0] <= cfg_data;
					qas_pkg::CFG_RESOLUTION_B: res_q[1] <= cfg_data;
					qas_pkg::CFG_INVERT_A:     inv_q[0] <= cfg_data[0];
					qas_pkg::CFG_INVERT_B:     inv_q[1] <= cfg_data[0];
					default: begin
					end
				endcase
			end

			// Entering the angle multiply from anywhere but idle starts channel B.
			if (state_q == qas_pkg::ST_IDLE) begin
				ch_q <= 1'b0;
			end else if ((state_q != qas_pkg::ST_ANG_MUL)
					&& (state_d == qas_pkg::ST_ANG_MUL)) begin
				ch_q <= 1'b1;
			end

			if (mul_start || div_start) begin
				issued_q <= 1'b1;
			end else if (mul_done || div_stat.done) begin
				issued_q <= 1'b0;
			end

			if (req_fire) begin
				case (req_item.req_type)
					qas_pkg::REQ_WRAP: begin
						if (req_item.wrap_upward) begin
							wrap_q[req_item.wrap_channel] <=
								wrap_q[req_item.wrap_channel] + qas_pkg::WRAP_W'(1);
						end else begin
							wrap_q[req_item.wrap_channel] <=
								wrap_q[req_item.wrap_channel] - qas_pkg::WRAP_W'(1);
						end
					end
					qas_pkg::REQ_TICK: begin
						// The tick counter sticks at its maximum.
						if (ticks_q != '1) begin
							ticks_q <= ticks_q + qas_pkg::TICK_W'(1);
						end
					end
					qas_pkg::REQ_SAMPLE: begin
						fresh_q <= (ticks_q != '0);
						if (req_item.clear_a) begin
							wrap_q[0] <= '0;
						end
						if (req_item.clear_b) begin
							wrap_q[1] <= '0;
						end
					end
					default: begin
					end
				endcase
			end

			if ((state_q == qas_pkg::ST_SPD_DIV) && div_stat.done) begin
				held_q[ch_q] <= qas_pkg::sat_word(diff_sel[qas_pkg::DIFF_W-1],
					div_stat.ovf, div_quot);
			end

			// The new positions become the reference once the speeds are out.
			if (rsp_load && fresh_q) begin
				prev_q[0] <= full_q[0];
				prev_q[1] <= full_q[1];
				ticks_q   <= '0;
			end

			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_fire) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Working registers and the result register.
	always_ff @(posedge clk) begin
		if (req_fire && (req_item.req_type == qas_pkg::REQ_SAMPLE)) begin
			full_q[0] <= pos_next[0];
			full_q[1] <= pos_next[1];
			diff_q[0] <= {pos_next[0][qas_pkg::POS_W-1], pos_next[0]}
				- {prev_q[0][qas_pkg::POS_W-1], prev_q[0]};
			diff_q[1] <= {pos_next[1][qas_pkg::POS_W-1], pos_next[1]}
				- {prev_q[1][qas_pkg::POS_W-1], prev_q[1]};
		end
		if ((state_q == qas_pkg::ST_ANG_DIV) && div_stat.done) begin
			ang_q[ch_q] <= qas_pkg::sat_word(full_sel[qas_pkg::POS_W-1] ^ inv_q[ch_q],
				div_stat.ovf, div_quot);
		end
		if ((state_q == qas_pkg::ST_DEN_MUL) && mul_done) begin
			den_q <= mul_prod[qas_pkg::DEN_W-1:0];
		end
		if (rsp_load) begin
			rsp_data_q.angle_a     <= ang_q[0];
			rsp_data_q.angle_b     <= ang_q[1];
			rsp_data_q.speed_a     <= held_q[0];
			rsp_data_q.speed_b     <= held_q[1];
			rsp_data_q.speed_fresh <= fresh_q;
		end
	end

	// The two arithmetic units never finish in the same cycle.
	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_done && div_stat.done))
		else $error("multiplier and divider finished together");

	// A unit only reports done for an operation the sequencer launched.
	a_done_was_issued: assert property (@(posedge clk) disable iff (!arst_n)
		(mul_done || div_stat.done) |-> issued_q)
		else $error("arithmetic unit finished without a launch");

	// A sample transfer starts with the channel A angle.
	a_sample_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && (req_item.req_type == qas_pkg::REQ_SAMPLE))
		|=> (state_q == qas_pkg::ST_ANG_MUL) && !ch_q)
		else $error("sample did not start on channel A");

	// A speed update restarts the tick count.
	a_ticks_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_load && fresh_q) |=> (ticks_q == '0))
		else $error("tick count not cleared after speed update");

	// A finished sample is always offered on the result channel.
	a_result_offered: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |=> rsp_ch.valid)
		else $error("finished sample not offered");

endmodule
